/* hdl/qalu_pkg.sv */
package qalu_pkg;

  localparam int unsigned COMPONENT_WIDTH = 16;
  localparam int unsigned CW = COMPONENT_WIDTH;
  localparam int unsigned FW = CW - 2;          // fraction bits
  localparam int unsigned PW = 2 * CW;          // product width
  localparam int unsigned SW = 2 * CW + 1;      // sum of squares width
  localparam int unsigned MW = 2 * CW + 2;      // product sum width
  localparam int unsigned RW = CW + 3;          // square root remainder width
  localparam int unsigned LAST_STEP = CW + 3;   // last digit stage
  localparam int unsigned DEPTH = CW + 4;       // output register stage

  localparam logic [2:0] FUNC_ADD  = 3'd0;
  localparam logic [2:0] FUNC_SUB  = 3'd1;
  localparam logic [2:0] FUNC_MUL  = 3'd2;
  localparam logic [2:0] FUNC_CONJ = 3'd3;
  localparam logic [2:0] FUNC_NORM = 3'd4;
  localparam logic [2:0] FUNC_INV  = 3'd5;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  typedef logic signed [CW-1:0] comp_t;

  localparam comp_t COMP_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(CW-1){1'b0}}};

  // hamilton product: lane k sums a[j]*b[j^k], bit j set where the term is subtracted
  localparam logic [3:0] NEG_TERMS [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  typedef struct packed {
    logic [2:0] func;
    comp_t      a_w;
    comp_t      a_x;
    comp_t      a_y;
    comp_t      a_z;
    comp_t      b_w;
    comp_t      b_x;
    comp_t      b_y;
    comp_t      b_z;
  } qalu_in_t;

  typedef struct packed {
    comp_t      r_w;
    comp_t      r_x;
    comp_t      r_y;
    comp_t      r_z;
    logic [1:0] status;
  } qalu_out_t;

  typedef struct packed {
    logic signed [CW:0] elem;
    comp_t              mres;
    logic               msat;
    comp_t              dval;
    logic               dsat;
  } qalu_lane_t;

  // returns {saturated, value}
  function automatic logic [CW:0] sat_comp(input logic signed [CW+3:0] v);
    logic signed [CW+3:0] hi;
    logic signed [CW+3:0] lo;
    logic [CW:0]          r;
    hi = {{4{COMP_MAX[CW-1]}}, COMP_MAX};
    lo = {{4{COMP_MIN[CW-1]}}, COMP_MIN};
    if (v > hi) begin
      r = {1'b1, COMP_MAX};
    end else if (v < lo) begin
      r = {1'b1, COMP_MIN};
    end else begin
      r = {1'b0, v[CW-1:0]};
    end
    return r;
  endfunction

endpackage

/* hdl/qalu_lane.sv */
module qalu_lane import qalu_pkg::*; #(
  parameter int unsigned LANE = 0
) (
  input  logic                 clk_i,
  input  logic [LAST_STEP:1]   en_i,
  input  qalu_in_t             in_i,
  input  logic [SW-1:0]        s_i,
  output logic [PW-1:0]        sq_o,
  output qalu_lane_t           res_o
);

  comp_t a [4];
  comp_t b [4];

  assign a[0] = in_i.a_w;
  assign a[1] = in_i.a_x;
  assign a[2] = in_i.a_y;
  assign a[3] = in_i.a_z;
  assign b[0] = in_i.b_w;
  assign b[1] = in_i.b_x;
  assign b[2] = in_i.b_y;
  assign b[3] = in_i.b_z;

  // stage 1: products and componentwise ops
  logic signed [PW-1:0] prod_d [4];
  logic signed [PW-1:0] prod_q [4];
  logic signed [PW-1:0] sq_d;
  logic signed [PW-1:0] sq_q;
  logic signed [CW:0]   elem_d;
  logic signed [CW:0]   elem1_q;
  comp_t                ak1_q;
  logic signed [CW:0]   ae;
  logic signed [CW:0]   be;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      prod_d[j] = a[j] * b[2'(j) ^ 2'(LANE)];
    end
    sq_d = a[LANE] * a[LANE];
    ae = {a[LANE][CW-1], a[LANE]};
    be = {b[LANE][CW-1], b[LANE]};
    case (in_i.func)
      FUNC_ADD:  elem_d = ae + be;
      FUNC_SUB:  elem_d = ae - be;
      FUNC_CONJ: elem_d = (LANE == 0) ? ae : -ae;
      default:   elem_d = ae;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_q  <= prod_d;
      sq_q    <= sq_d;
      elem1_q <= elem_d;
      ak1_q   <= a[LANE];
    end
  end

  assign sq_o = sq_q;

  // stage 2: signed sum of products, round half up, saturate
  logic signed [MW-1:0] msum;
  logic signed [MW-1:0] mrnd;
  logic [CW:0]          msat_d;
  comp_t                mres2_q;
  logic                 msat2_q;
  logic signed [CW:0]   elem2_q;
  comp_t                ak2_q;

  always_comb begin
    msum = '0;
    for (int j = 0; j < 4; j++) begin
      if (NEG_TERMS[LANE][j]) begin
        msum = msum - {{2{prod_q[j][PW-1]}}, prod_q[j]};
      end else begin
        msum = msum + {{2{prod_q[j][PW-1]}}, prod_q[j]};
      end
    end
    mrnd   = (msum + (MW'(1) << (FW - 1))) >>> FW;
    msat_d = sat_comp(mrnd[CW+3:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      mres2_q <= msat_d[CW-1:0];
      msat2_q <= msat_d[CW];
      elem2_q <= elem1_q;
      ak2_q   <= ak1_q;
    end
  end

  // stage 3: divider setup, quotient overflow check of mag << (CW - 4) against s
  logic [CW-1:0] mag_d;
  logic          neg_d;
  logic [SW-1:0] rem0_d;

  always_comb begin
    mag_d  = ak2_q[CW-1] ? CW'(-ak2_q) : CW'(ak2_q);
    neg_d  = (LANE == 0) ? ak2_q[CW-1] : (ak2_q != '0 && !ak2_q[CW-1]);
    rem0_d = SW'(mag_d) << (CW - 4);
  end

  logic [SW-1:0]      rem_q  [LAST_STEP:3];
  logic [CW-1:0]      quo_q  [LAST_STEP:3];
  logic [SW-1:0]      s_q    [LAST_STEP:3];
  logic               ovf_q  [LAST_STEP:3];
  logic               neg_q  [LAST_STEP:3];
  comp_t              mres_q [LAST_STEP:3];
  logic               msat_q [LAST_STEP:3];
  logic signed [CW:0] elem_q [LAST_STEP:3];

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      rem_q[3]  <= rem0_d;
      quo_q[3]  <= '0;
      s_q[3]    <= s_i;
      ovf_q[3]  <= rem0_d >= s_i;
      neg_q[3]  <= neg_d;
      mres_q[3] <= mres2_q;
      msat_q[3] <= msat2_q;
      elem_q[3] <= elem2_q;
    end
  end

  // one quotient bit per stage, restoring division
  for (genvar k = 4; k <= LAST_STEP; k++) begin : g_step
    logic [SW:0] t;
    logic        ge;

    assign t  = {rem_q[k-1], 1'b0};
    assign ge = t >= {1'b0, s_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k]  <= ge ? SW'(t - {1'b0, s_q[k-1]}) : SW'(t);
        quo_q[k]  <= {quo_q[k-1][CW-2:0], ge};
        s_q[k]    <= s_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        mres_q[k] <= mres_q[k-1];
        msat_q[k] <= msat_q[k-1];
        elem_q[k] <= elem_q[k-1];
      end
    end
  end

  // round half away from zero, then saturate
  logic          rup;
  logic [CW:0]   qr;
  logic [CW:0]   lim;
  logic [CW-1:0] qlow;
  logic          dsat;

  always_comb begin
    rup  = {rem_q[LAST_STEP], 1'b0} >= {1'b0, s_q[LAST_STEP]};
    qr   = {1'b0, quo_q[LAST_STEP]} + (CW+1)'(rup);
    lim  = neg_q[LAST_STEP] ? ((CW+1)'(1) << (CW - 1)) : (((CW+1)'(1) << (CW - 1)) - 1'b1);
    dsat = ovf_q[LAST_STEP] || (qr > lim);
    qlow = qr[CW-1:0];
    res_o.elem = elem_q[LAST_STEP];
    res_o.mres = mres_q[LAST_STEP];
    res_o.msat = msat_q[LAST_STEP];
    res_o.dsat = dsat;
    if (dsat) begin
      res_o.dval = neg_q[LAST_STEP] ? COMP_MIN : COMP_MAX;
    end else begin
      res_o.dval = neg_q[LAST_STEP] ? comp_t'(-qlow) : comp_t'(qlow);
    end
  end

endmodule

/* hdl/qalu_sqrt.sv */
module qalu_sqrt import qalu_pkg::*; (
  input  logic                 clk_i,
  input  logic [LAST_STEP:3]   en_i,
  input  logic [SW-1:0]        s_i,
  output logic [CW:0]          root_o
);

  logic [MW-1:0] rad_q  [LAST_STEP-1:3];
  logic [RW-1:0] rem_q  [LAST_STEP:3];
  logic [CW:0]   root_q [LAST_STEP:3];

  // one root bit per stage, two radicand bits consumed per stage
  for (genvar k = 3; k <= LAST_STEP; k++) begin : g_step
    localparam int unsigned Pos = 2 * (LAST_STEP - k);
    logic [MW-1:0] rad_in;
    logic [RW-1:0] rem_in;
    logic [CW:0]   root_in;
    logic [RW+1:0] t;
    logic [RW+1:0] trial;
    logic          ge;

    if (k == 3) begin : g_first
      assign rad_in  = {1'b0, s_i};
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign t     = {rem_in, rad_in[Pos+1:Pos]};
    assign trial = (RW+2)'({root_in, 2'b01});
    assign ge    = t >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k]  <= ge ? RW'(t - trial) : RW'(t);
        root_q[k] <= {root_in[CW-1:0], ge};
      end
    end

    if (k < LAST_STEP) begin : g_rad
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          rad_q[k] <= rad_in;
        end
      end
    end
  end

  // round to nearest: remainder above root means the root plus one half is exceeded
  assign root_o = root_q[LAST_STEP]
                + (CW+1)'(rem_q[LAST_STEP] > {2'b00, root_q[LAST_STEP]});

endmodule

/* hdl/quaternion_alu.sv */
// quaternion_alu: add, subtract, hamilton product, conjugate, norm and
// inverse of signed q1.14 quaternions.
// input channel: in_valid_i / in_ready_o with in_data_i (func, a, b); a
// transfer happens when valid and ready are both high at a clock edge.
// output channel: out_valid_o / out_ready_i with out_data_o (r, status).
// every input item gives exactly one result, in order.
// every operation passes through the same stages from input transfer to
// out_valid_o: one stage for products, one for the
// product sums and sum of squares, CW + 1 stages of the digit pipelines
// (square root one root bit per stage, divider lanes a setup stage, then
// one quotient bit per stage), and the output register.
// throughput: one item per cycle, unless a stalled receiver has filled every stage.
// a stalled receiver holds the output register; the stages behind it keep
// filling and in_ready_o drops only once every stage holds an item.
// reset clears all stage valid bits; no result is pending after reset.
module quaternion_alu import qalu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  qalu_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output qalu_out_t out_data_o
);

  logic [DEPTH:1] v_q;
  logic [DEPTH:1] en;

  // a stage advances when the receiver is ready or when it or any stage after it has a free slot
  for (genvar k = 1; k <= DEPTH; k++) begin : g_en
    assign en[k] = out_ready_i | ~(&v_q[DEPTH:k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= DEPTH; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o = en[1];

  // component lanes
  logic [PW-1:0] sq   [4];
  qalu_lane_t    lane [4];
  logic [SW-1:0] s_q;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    qalu_lane #(
      .LANE(i)
    ) u_lane (
      .clk_i(clk_i),
      .en_i (en[LAST_STEP:1]),
      .in_i (in_data_i),
      .s_i  (s_q),
      .sq_o (sq[i]),
      .res_o(lane[i])
    );
  end

  // operation code and zero-norm flag travel alongside the lanes
  logic [2:0] func_q [LAST_STEP:1];
  logic       zero_q [LAST_STEP:2];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      func_q[1] <= in_data_i.func;
    end
    if (en[2]) begin
      func_q[2] <= func_q[1];
      s_q       <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]) + SW'(sq[3]);
      zero_q[2] <= (sq[0] == '0) && (sq[1] == '0) && (sq[2] == '0) && (sq[3] == '0);
    end
    for (int k = 3; k <= LAST_STEP; k++) begin
      if (en[k]) begin
        func_q[k] <= func_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  logic [CW:0] root;

  qalu_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (en[LAST_STEP:3]),
    .s_i   (s_q),
    .root_o(root)
  );

  // merge: pick the result for the operation, combine saturation flags
  comp_t       comp [4];
  logic [3:0]  flag;
  logic [CW:0] es;
  logic [2:0]  fcode;
  logic        zero;
  qalu_out_t   out_d;
  qalu_out_t   out_q;

  always_comb begin
    fcode = func_q[LAST_STEP];
    zero  = zero_q[LAST_STEP];
    es    = '0;
    for (int i = 0; i < 4; i++) begin
      comp[i] = '0;
      flag[i] = 1'b0;
    end
    unique case (fcode) inside
      FUNC_ADD, FUNC_SUB, FUNC_CONJ: begin
        for (int i = 0; i < 4; i++) begin
          es      = sat_comp({{3{lane[i].elem[CW]}}, lane[i].elem});
          comp[i] = es[CW-1:0];
          flag[i] = es[CW];
        end
      end
      FUNC_MUL: begin
        for (int i = 0; i < 4; i++) begin
          comp[i] = lane[i].mres;
          flag[i] = lane[i].msat;
        end
      end
      FUNC_NORM: begin
        flag[0] = root > {1'b0, COMP_MAX};
        comp[0] = flag[0] ? COMP_MAX : comp_t'(root[CW-1:0]);
      end
      FUNC_INV: begin
        if (!zero) begin
          for (int i = 0; i < 4; i++) begin
            comp[i] = lane[i].dval;
            flag[i] = lane[i].dsat;
          end
        end
      end
      default: ;
    endcase
    out_d.r_w = comp[0];
    out_d.r_x = comp[1];
    out_d.r_y = comp[2];
    out_d.r_z = comp[3];
    if (fcode == FUNC_INV && zero) begin
      out_d.status = STATUS_ZERO;
    end else if (|flag) begin
      out_d.status = STATUS_SAT;
    end else begin
      out_d.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[DEPTH]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v_q[DEPTH];
  assign out_data_o  = out_q;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[DEPTH] |-> in_ready_o)
    else $error("input stalled with an empty output stage");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[1])
    else $error("accepted item lost in the first stage");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[DEPTH] |-> (out_q.status == STATUS_OK || out_q.status == STATUS_ZERO ||
                    out_q.status == STATUS_SAT))
    else $error("invalid status code");

  a_zero_norm_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[DEPTH] && out_q.status == STATUS_ZERO |->
      out_q.r_w == '0 && out_q.r_x == '0 && out_q.r_y == '0 && out_q.r_z == '0)
    else $error("zero-norm inverse with nonzero components");

endmodule
